// ===== rtl/core/vector4_arith_unit_top_defines.svh =====
// assertion macros for the vector arithmetic unit
`ifndef VECTOR4_ARITH_UNIT_TOP_DEFINES_SVH
`define VECTOR4_ARITH_UNIT_TOP_DEFINES_SVH

// same-cycle implication
`define V4AU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define V4AU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/v4au_pkg.sv =====
package v4au_pkg;

   typedef enum logic [3:0] {
      CMD_NEG  = 4'd0,
      CMD_ADD  = 4'd1,
      CMD_SUB  = 4'd2,
      CMD_ADDS = 4'd3,
      CMD_SUBS = 4'd4,
      CMD_SMIN = 4'd5,
      CMD_MUL  = 4'd6,
      CMD_DIV  = 4'd7,
      CMD_DOT  = 4'd8,
      CMD_LEN  = 4'd9,
      CMD_NORM = 4'd10
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_SAT = 2'd1,
      ST_DZ  = 2'd2
   } status_type;

   localparam int LANES      = 4;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 33;
   localparam int SQRT_FIRST = 3;
   localparam int LROUND     = SQRT_FIRST + SQRT_STEPS;
   localparam int NUMER      = LROUND + 1;
   localparam int OVFCHK     = NUMER + 1;
   localparam int DIV_FIRST  = OVFCHK + 1;
   localparam int LAST       = DIV_FIRST + DIV_STEPS;
   localparam int PIPE_DEPTH = LAST + 1;

   localparam logic signed [65:0] QMAX = 66'sd2147483647;
   localparam logic signed [65:0] QMIN = -66'sd2147483648;

   typedef struct packed {
      logic [3:0]         command;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] a_t;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] b_t;
      logic signed [31:0] scalar_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic signed [31:0] r_t;
      logic signed [31:0] r_scalar;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [3:0]                  cmd;
      logic [LANES-1:0][31:0]      a;
      logic [LANES-1:0][31:0]      b;
      logic [31:0]                 s;
      logic [LANES-1:0][31:0]      r;
      logic [LANES-1:0]            lsat;
      logic [LANES-1:0][63:0]      prod;
      logic [1:0][64:0]            psum;
      logic [63:0]                 rv;
      logic [63:0]                 rres;
      logic                        carry;
      logic                        zero;
      logic [31:0]                 rs;
      logic                        ssat;
      logic [32:0]                 den;
      logic [LANES-1:0][47:0]      rem;
      logic [LANES-1:0][32:0]      q;
      logic [LANES-1:0]            ovf;
   } pipe_type;

   typedef struct packed {
      logic        sat;
      logic [31:0] val;
   } clamp_type;

   function automatic clamp_type sat32(input logic signed [65:0] v);
      clamp_type c;
      if (v > QMAX) begin
         c.sat = 1'b1;
         c.val = 32'h7fff_ffff;
      end else if (v < QMIN) begin
         c.sat = 1'b1;
         c.val = 32'h8000_0000;
      end else begin
         c.sat = 1'b0;
         c.val = v[31:0];
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/v4au_lane.sv =====
module v4au_lane import v4au_pkg::*; (
   input  logic [3:0]  cmd,
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  logic [31:0] s,
   output logic [31:0] r,
   output logic        sat,
   output logic [63:0] prod
);

   logic signed [65:0] sa;
   logic signed [65:0] sb;
   logic signed [65:0] ss;
   logic signed [65:0] sum;
   logic [31:0]        m;
   logic signed [63:0] pw;
   clamp_type          c;

   assign sa = 66'($signed(a));
   assign sb = 66'($signed(b));
   assign ss = 66'($signed(s));

   always_comb begin
      case (cmd)
         CMD_NEG:  sum = -sa;
         CMD_ADD:  sum = sa + sb;
         CMD_SUB:  sum = sa - sb;
         CMD_ADDS: sum = sa + ss;
         CMD_SUBS: sum = sa - ss;
         CMD_SMIN: sum = ss - sa;
         default:  sum = '0;
      endcase
   end

   assign c   = sat32(sum);
   assign r   = c.val;
   assign sat = c.sat;

   // one shared multiplier: a*s, a*b or a*a
   always_comb begin
      if (cmd == CMD_MUL) begin
         m = s;
      end else if (cmd == CMD_DOT) begin
         m = b;
      end else begin
         m = a;
      end
   end

   assign pw   = $signed(a) * $signed(m);
   assign prod = pw;

endmodule

// ===== rtl/core/v4au_merge.sv =====
module v4au_merge import v4au_pkg::*; (
   input  pipe_type d_in,
   output pipe_type d_out
);

   logic signed [65:0] total;
   logic signed [65:0] rnd;
   clamp_type          c;

   assign total = 66'($signed(d_in.psum[0])) + 66'($signed(d_in.psum[1]));
   assign rnd   = (total + 66'sd32768) >>> 16;
   assign c     = sat32(rnd);

   always_comb begin
      d_out = d_in;
      if (d_in.cmd == CMD_DOT) begin
         d_out.rs   = c.val;
         d_out.ssat = c.sat;
      end
      // sum of squares feeds the root
      d_out.rv    = total[63:0];
      d_out.rres  = '0;
      d_out.carry = total[64];
      d_out.zero  = !total[64] && (total[63:0] == 64'd0);
   end

endmodule

// ===== rtl/core/v4au_sqrt_step.sv =====
module v4au_sqrt_step import v4au_pkg::*; (
   input  pipe_type   d_in,
   input  logic [4:0] step,
   output pipe_type   d_out
);

   logic [63:0] bitv;
   logic [63:0] trial;

   assign bitv  = 64'd1 << (6'd62 - {step, 1'b0});
   assign trial = d_in.rres + bitv;

   always_comb begin
      d_out = d_in;
      if (d_in.rv >= trial) begin
         d_out.rv   = d_in.rv - trial;
         d_out.rres = (d_in.rres >> 1) + bitv;
      end else begin
         d_out.rres = d_in.rres >> 1;
      end
   end

endmodule

// ===== rtl/core/v4au_div_step.sv =====
module v4au_div_step import v4au_pkg::*; (
   input  logic [47:0] rem,
   input  logic [32:0] den,
   input  logic [5:0]  shift,
   output logic [47:0] rem_out,
   output logic        qbit
);

   logic [65:0] dsh;

   assign dsh     = 66'(den) << shift;
   assign qbit    = 66'(rem) >= dsh;
   assign rem_out = qbit ? (rem - dsh[47:0]) : rem;

endmodule

// ===== rtl/core/vector4_arith_unit_top.sv =====
// channel   dir  ports                          word
// req       in   req_valid req_ready req_data   command, vectors a and b, scalar
// rsp       out  rsp_valid rsp_ready rsp_data   vector, scalar, status
// one word per cycle while rsp_ready does not stall the output
// depth is set by the 32-step square root and the 33-step divider lanes
// reset is synchronous and clears only the valid bits
// rsp_ready low holds the output word; bubbles inside the pipe close up
// req_ready drops only when every stage holds a word and the output word is stalled
module vector4_arith_unit_top import v4au_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   pipe_type                st_ff [PIPE_DEPTH];
   wire pipe_type           st_in [PIPE_DEPTH];
   logic [PIPE_DEPTH-1:0]   vld_ff;
   logic [PIPE_DEPTH-1:0]   vld_in;
   logic [PIPE_DEPTH-1:0]   en;
   logic                    out_en;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;
   rsp_type                 rsp_in;

   logic [LANES-1:0][31:0]  lane_r;
   logic [LANES-1:0]        lane_sat;
   logic [LANES-1:0][63:0]  lane_prod;

   pipe_type                st0_in;
   pipe_type                st1_in;
   pipe_type                st2_in;
   pipe_type                rnd_in;
   pipe_type                num_in;
   pipe_type                ovf_in;

   // flow control
   assign out_en = !rsp_valid_ff || rsp_ready;

   always_comb begin
      en[LAST] = !vld_ff[LAST] || out_en;
      for (int k = LAST - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];
   assign vld_in    = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
         if (en[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // capture
   always_comb begin
      st0_in      = '0;
      st0_in.cmd  = req_data.command;
      st0_in.a[0] = req_data.a_x;
      st0_in.a[1] = req_data.a_y;
      st0_in.a[2] = req_data.a_z;
      st0_in.a[3] = req_data.a_t;
      st0_in.b[0] = req_data.b_x;
      st0_in.b[1] = req_data.b_y;
      st0_in.b[2] = req_data.b_z;
      st0_in.b[3] = req_data.b_t;
      st0_in.s    = req_data.scalar_in;
   end
   assign st_in[0] = st0_in;

   // lanes: elementwise ops and products
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      v4au_lane u_lane (
         .cmd  (st_ff[0].cmd),
         .a    (st_ff[0].a[i]),
         .b    (st_ff[0].b[i]),
         .s    (st_ff[0].s),
         .r    (lane_r[i]),
         .sat  (lane_sat[i]),
         .prod (lane_prod[i])
      );
   end

   always_comb begin
      st1_in = st_ff[0];
      for (int i = 0; i < LANES; i++) begin
         st1_in.r[i]    = lane_r[i];
         st1_in.lsat[i] = lane_sat[i];
         st1_in.prod[i] = lane_prod[i];
      end
   end
   assign st_in[1] = st1_in;

   // product rounding and first level of the sum tree
   always_comb begin : c_mulrnd
      logic signed [63:0] t;
      clamp_type          c;
      st2_in = st_ff[1];
      for (int i = 0; i < LANES; i++) begin
         t = $signed(st_ff[1].prod[i]) + 64'sd32768;
         c = sat32(66'(t >>> 16));
         if (st_ff[1].cmd == CMD_MUL) begin
            st2_in.r[i]    = c.val;
            st2_in.lsat[i] = c.sat;
         end
      end
      st2_in.psum[0] = 65'($signed(st_ff[1].prod[0])) + 65'($signed(st_ff[1].prod[1]));
      st2_in.psum[1] = 65'($signed(st_ff[1].prod[2])) + 65'($signed(st_ff[1].prod[3]));
   end
   assign st_in[2] = st2_in;

   v4au_merge u_merge (
      .d_in  (st_ff[2]),
      .d_out (st_in[3])
   );

   for (genvar k = SQRT_FIRST; k < LROUND; k++) begin : g_sqrt
      v4au_sqrt_step u_step (
         .d_in  (st_ff[k]),
         .step  (5'(k - SQRT_FIRST)),
         .d_out (st_in[k+1])
      );
   end

   // rounded length and divisor
   always_comb begin : c_round
      logic [32:0] len;
      logic [32:0] smag;
      rnd_in = st_ff[LROUND];
      if (st_ff[LROUND].carry) begin
         len = 33'h1_0000_0000;
      end else begin
         len = 33'(st_ff[LROUND].rres[31:0])
             + 33'(st_ff[LROUND].rv > st_ff[LROUND].rres);
      end
      if (st_ff[LROUND].cmd == CMD_LEN) begin
         if (len > 33'h0_7fff_ffff) begin
            rnd_in.rs   = 32'h7fff_ffff;
            rnd_in.ssat = 1'b1;
         end else begin
            rnd_in.rs = len[31:0];
         end
      end
      if (st_ff[LROUND].s[31]) begin
         smag = ~{1'b1, st_ff[LROUND].s} + 33'd1;
      end else begin
         smag = {1'b0, st_ff[LROUND].s};
      end
      rnd_in.den = (st_ff[LROUND].cmd == CMD_DIV) ? smag : len;
   end
   assign st_in[LROUND+1] = rnd_in;

   // numerators with half divisor for rounding
   always_comb begin : c_numer
      logic [32:0] amag;
      num_in = st_ff[NUMER];
      for (int i = 0; i < LANES; i++) begin
         if (st_ff[NUMER].a[i][31]) begin
            amag = ~{1'b1, st_ff[NUMER].a[i]} + 33'd1;
         end else begin
            amag = {1'b0, st_ff[NUMER].a[i]};
         end
         num_in.rem[i] = {amag[31:0], 16'd0} + 48'(st_ff[NUMER].den >> 1);
         num_in.q[i]   = '0;
      end
   end
   assign st_in[NUMER+1] = num_in;

   // quotient beyond 33 bits
   always_comb begin
      ovf_in = st_ff[OVFCHK];
      for (int i = 0; i < LANES; i++) begin
         ovf_in.ovf[i] = 66'(st_ff[OVFCHK].rem[i]) >= (66'(st_ff[OVFCHK].den) << 33);
      end
   end
   assign st_in[OVFCHK+1] = ovf_in;

   for (genvar k = DIV_FIRST; k < LAST; k++) begin : g_div
      logic [LANES-1:0][47:0] rem_nxt;
      logic [LANES-1:0]       qbit;
      pipe_type               nxt;

      for (genvar i = 0; i < LANES; i++) begin : g_dlane
         v4au_div_step u_div (
            .rem     (st_ff[k].rem[i]),
            .den     (st_ff[k].den),
            .shift   (6'(LAST - 1 - k)),
            .rem_out (rem_nxt[i]),
            .qbit    (qbit[i])
         );
      end

      always_comb begin
         nxt = st_ff[k];
         for (int i = 0; i < LANES; i++) begin
            nxt.rem[i]           = rem_nxt[i];
            nxt.q[i][LAST-1-k]   = qbit[i];
         end
      end
      assign st_in[k+1] = nxt;
   end

   // result assembly
   always_comb begin : c_final
      pipe_type               p;
      logic [LANES-1:0]       dsat;
      logic [LANES-1:0][31:0] dval;
      logic [LANES-1:0][31:0] vr;
      logic [31:0]            sr;
      logic                   neg;
      status_type             stat;
      p    = st_ff[LAST];
      vr   = '0;
      sr   = '0;
      stat = ST_OK;
      for (int i = 0; i < LANES; i++) begin
         neg = (p.cmd == CMD_DIV) ? (p.a[i][31] ^ p.s[31]) : p.a[i][31];
         dsat[i] = 1'b0;
         if (p.ovf[i]) begin
            dsat[i] = 1'b1;
            dval[i] = neg ? 32'h8000_0000 : 32'h7fff_ffff;
         end else if (neg) begin
            if (p.q[i] > 33'h0_8000_0000) begin
               dsat[i] = 1'b1;
               dval[i] = 32'h8000_0000;
            end else begin
               dval[i] = 32'(33'd0 - p.q[i]);
            end
         end else begin
            if (p.q[i] > 33'h0_7fff_ffff) begin
               dsat[i] = 1'b1;
               dval[i] = 32'h7fff_ffff;
            end else begin
               dval[i] = p.q[i][31:0];
            end
         end
      end
      case (p.cmd)
         CMD_NEG, CMD_ADD, CMD_SUB, CMD_ADDS, CMD_SUBS, CMD_SMIN, CMD_MUL: begin
            vr   = p.r;
            stat = (|p.lsat) ? ST_SAT : ST_OK;
         end
         CMD_DIV: begin
            if (p.s == 32'd0) begin
               for (int i = 0; i < LANES; i++) begin
                  if (p.a[i][31]) begin
                     vr[i] = 32'h8000_0000;
                  end else if (p.a[i] != 32'd0) begin
                     vr[i] = 32'h7fff_ffff;
                  end else begin
                     vr[i] = 32'd0;
                  end
               end
               stat = ST_DZ;
            end else begin
               vr   = dval;
               stat = (|dsat) ? ST_SAT : ST_OK;
            end
         end
         CMD_DOT, CMD_LEN: begin
            sr   = p.rs;
            stat = p.ssat ? ST_SAT : ST_OK;
         end
         CMD_NORM: begin
            if (p.zero) begin
               vr = p.a;
            end else begin
               vr   = dval;
               stat = (|dsat) ? ST_SAT : ST_OK;
            end
         end
         default: begin
            vr = '0;
         end
      endcase
      rsp_in.r_x      = vr[0];
      rsp_in.r_y      = vr[1];
      rsp_in.r_z      = vr[2];
      rsp_in.r_t      = vr[3];
      rsp_in.r_scalar = sr;
      rsp_in.status   = stat;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && vld_ff[LAST]) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/v4au_checker.sv =====
`include "vector4_arith_unit_top_defines.svh"

module v4au_checker import v4au_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `V4AU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result word changed while stalled")
   `V4AU_ASSERT_NOW(a_req_ready, !rsp_valid || rsp_ready, req_ready, "input stalled with output free")
   `V4AU_ASSERT_NOW(a_scalar_excl, rsp_valid && rsp_data.r_scalar != 32'd0, rsp_data.r_x == 32'd0 && rsp_data.r_y == 32'd0 && rsp_data.r_z == 32'd0 && rsp_data.r_t == 32'd0, "scalar and vector both set")
   `V4AU_ASSERT_NOW(a_dz_scalar, rsp_valid && rsp_data.status == ST_DZ, rsp_data.r_scalar == 32'd0, "divide by zero with scalar result")

endmodule

bind vector4_arith_unit_top v4au_checker u_v4au_checker (.*);

// ===== test/vector4_arith_unit_checker.sv =====
module vector4_arith_unit_checker import v4au_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      word_count
);

   rsp_type expected_words[$];
   int      status_seen[3];

   function automatic logic signed [65:0] clamp_q(input logic signed [65:0] v, ref logic sat);
      if (v > 66'sd2147483647) begin
         sat = 1'b1;
         return 66'sd2147483647;
      end
      if (v < -66'sd2147483648) begin
         sat = 1'b1;
         return -66'sd2147483648;
      end
      return v;
   endfunction

   // round to nearest, ties away from zero, den > 0
   function automatic logic signed [65:0] round_div(input logic signed [65:0] num,
                                                     input logic [65:0] den);
      logic [65:0] mag;
      logic [65:0] q;
      mag = num < 0 ? 66'(-num) : 66'(num);
      q = (mag + den / 2) / den;
      return num < 0 ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [65:0] vector_length(input logic signed [31:0] v[4],
                                                 output logic is_zero);
      logic [65:0] sum;
      logic [65:0] root;
      logic [65:0] bitv;
      logic [65:0] rest;
      sum = 0;
      for (int i = 0; i < 4; i++) sum += 66'($signed(v[i]) * $signed(v[i]));
      is_zero = (sum == 0);
      if (sum >= 66'h1_0000_0000_0000_0000) return 66'h1_0000_0000;
      rest = sum;
      root = 0;
      bitv = 66'h1 << 64;
      while (bitv > rest) bitv >>= 2;
      while (bitv != 0) begin
         if (rest >= root + bitv) begin
            rest -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      if (sum - root * root > root) root++;
      return root;
   endfunction

   function automatic rsp_type compute_vector(input req_type w);
      rsp_type o;
      logic signed [31:0] a[4];
      logic signed [31:0] b[4];
      logic signed [65:0] r[4];
      logic signed [65:0] s;
      logic signed [65:0] acc;
      logic signed [65:0] rs;
      logic [65:0] len;
      logic sat;
      logic dz;
      logic is_zero;
      a = '{w.a_x, w.a_y, w.a_z, w.a_t};
      b = '{w.b_x, w.b_y, w.b_z, w.b_t};
      s = w.scalar_in;
      sat = 0;
      dz = 0;
      rs = 0;
      r = '{default: 0};
      case (w.command)
         CMD_NEG:  for (int i = 0; i < 4; i++) r[i] = clamp_q(-66'(a[i]), sat);
         CMD_ADD:  for (int i = 0; i < 4; i++) r[i] = clamp_q(66'(a[i]) + b[i], sat);
         CMD_SUB:  for (int i = 0; i < 4; i++) r[i] = clamp_q(66'(a[i]) - b[i], sat);
         CMD_ADDS: for (int i = 0; i < 4; i++) r[i] = clamp_q(66'(a[i]) + s, sat);
         CMD_SUBS: for (int i = 0; i < 4; i++) r[i] = clamp_q(66'(a[i]) - s, sat);
         CMD_SMIN: for (int i = 0; i < 4; i++) r[i] = clamp_q(s - a[i], sat);
         CMD_MUL:
            for (int i = 0; i < 4; i++) r[i] = clamp_q((66'(a[i]) * s + 32768) >>> 16, sat);
         CMD_DIV: begin
            if (s == 0) begin
               dz = 1;
               for (int i = 0; i < 4; i++)
                  r[i] = a[i] > 0 ? 66'sd2147483647 : (a[i] < 0 ? -66'sd2147483648 : 0);
            end else begin
               for (int i = 0; i < 4; i++) begin
                  acc = round_div(66'(a[i]) * 65536, s < 0 ? 66'(-s) : 66'(s));
                  r[i] = clamp_q(s < 0 ? -acc : acc, sat);
               end
            end
         end
         CMD_DOT: begin
            acc = 0;
            for (int i = 0; i < 4; i++) acc += 66'(a[i]) * b[i];
            rs = clamp_q((acc + 32768) >>> 16, sat);
         end
         CMD_LEN: begin
            len = vector_length(a, is_zero);
            if (len > 66'd2147483647) begin
               sat = 1;
               rs = 66'sd2147483647;
            end else begin
               rs = $signed(len);
            end
         end
         CMD_NORM: begin
            len = vector_length(a, is_zero);
            for (int i = 0; i < 4; i++)
               r[i] = is_zero ? 66'(a[i]) : clamp_q(round_div(66'(a[i]) * 65536, len), sat);
         end
         default: ;
      endcase
      o.r_x = r[0][31:0];
      o.r_y = r[1][31:0];
      o.r_z = r[2][31:0];
      o.r_t = r[3][31:0];
      o.r_scalar = rs[31:0];
      o.status = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
      return o;
   endfunction

   assign pending_count = expected_words.size();

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
         word_count <= 0;
      end else begin
         if (req_valid && req_ready) expected_words.push_back(compute_vector(req_data));
         if (rsp_valid && rsp_ready) begin
            word_count <= word_count + 1;
            if (expected_words.size() == 0) begin
               $error("unexpected rsp word %h", rsp_data);
               errs++;
            end else begin
               want = expected_words.pop_front();
               status_seen[want.status]++;
               if (rsp_data.r_x !== want.r_x) begin
                  $error("r_x exp %h got %h", want.r_x, rsp_data.r_x);
                  errs++;
               end
               if (rsp_data.r_y !== want.r_y) begin
                  $error("r_y exp %h got %h", want.r_y, rsp_data.r_y);
                  errs++;
               end
               if (rsp_data.r_z !== want.r_z) begin
                  $error("r_z exp %h got %h", want.r_z, rsp_data.r_z);
                  errs++;
               end
               if (rsp_data.r_t !== want.r_t) begin
                  $error("r_t exp %h got %h", want.r_t, rsp_data.r_t);
                  errs++;
               end
               if (rsp_data.r_scalar !== want.r_scalar) begin
                  $error("r_scalar exp %h got %h", want.r_scalar, rsp_data.r_scalar);
                  errs++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status exp %0d got %0d", want.status, rsp_data.status);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

   final begin
      if (expected_words.size() != 0) $error("%0d words never came", expected_words.size());
   end

endmodule

// ===== test/testbench.sv =====
module testbench import v4au_pkg::*;;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      word_count;
   bit      calm = 0;
   bit      stimulus_done = 0;
   bit      long_stall_done = 0;
   int      sent = 0;

   always #5 clock = ~clock;

   vector4_arith_unit_top u_dut (.*);

   vector4_arith_unit_checker u_checker (.*);

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return $urandom_range(0, 3) << 16;
         4: return -($urandom_range(0, 3) << 16);
         5: return $urandom_range(0, 32'h3ffff) - 32'h20000;
         6: return 32'h8000_0000 | $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input req_type w);
      req_valid <= 1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   function automatic req_type make_word(input logic [3:0] c, input logic [31:0] a,
                                         input logic [31:0] b, input logic [31:0] s);
      req_type w;
      w.command = c;
      w.a_x = a; w.a_y = a; w.a_z = a; w.a_t = a;
      w.b_x = b; w.b_y = b; w.b_z = b; w.b_t = b;
      w.scalar_in = s;
      return w;
   endfunction

   function automatic req_type random_word();
      req_type w;
      w.command = $urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 10))
                                             : 4'($urandom_range(11, 15));
      w.a_x = pick_value(); w.a_y = pick_value(); w.a_z = pick_value(); w.a_t = pick_value();
      w.b_x = pick_value(); w.b_y = pick_value(); w.b_z = pick_value(); w.b_t = pick_value();
      w.scalar_in = pick_value();
      if ($urandom_range(0, 7) == 0) w.scalar_in = 0;
      if (w.command == CMD_NORM && $urandom_range(0, 5) == 0) begin
         w.a_x = 0; w.a_y = 0; w.a_z = 0; w.a_t = 0;
      end
      return w;
   endfunction

   // receiver side
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      while (1) begin
         if (!calm && !long_stall_done && sent > 150) begin
            long_stall_done = 1;
            rsp_ready <= 0;
            repeat (300) @(negedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_ready <= 1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   initial begin
      req_type w;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int c = 0; c < 16; c++) begin
         send_word(make_word(4'(c), 32'h7fff_ffff, 32'h8000_0000, 32'h0));
      end
      send_word(make_word(CMD_NEG, 32'h8000_0000, 0, 0));
      send_word(make_word(CMD_NORM, 0, 0, 0));
      send_word(make_word(CMD_NORM, 32'h8000_0000, 0, 0));
      send_word(make_word(CMD_LEN, 32'h8000_0000, 0, 0));
      send_word(make_word(CMD_DIV, 0, 0, 0));
      send_word(make_word(CMD_MUL, 32'h0001_8000, 0, 32'h0000_8000));
      send_word(make_word(CMD_DIV, 32'hffff_ffff, 0, 32'h0002_0000));
      send_word(make_word(CMD_DOT, 32'h8000_0000, 32'h8000_0000, 0));
      for (int i = 0; i < 650; i++) begin
         if (i == 300) begin
            req_valid <= 0;
            while (pending_count != 0) @(negedge clock);
         end
         if (i == 550) calm = 1;
         send_word(random_word());
      end
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("sent %0d words, %0d results checked, all commands with saturation,",
               sent, word_count);
      $display("divide by zero, zero-vector normalize and a long output stall");
      if (fail_count == 0 && pending_count == 0) begin
         $display("[vector4_arith_unit_top] OK");
      end else begin
         $display("[vector4_arith_unit_top] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[vector4_arith_unit_top] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/v4au_pkg.sv
rtl/core/v4au_lane.sv
rtl/core/v4au_merge.sv
rtl/core/v4au_sqrt_step.sv
rtl/core/v4au_div_step.sv
rtl/core/vector4_arith_unit_top.sv
rtl/core/v4au_checker.sv
test/vector4_arith_unit_checker.sv
test/testbench.sv
